// ----- sv/uot_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uot_pkg
// Shared types and codes for the unspent output table.
// ----------------------------------------------------------------------------
package uot_pkg;

    localparam int ID_WORDS  = 4;
    localparam int WORD_W    = 64;
    localparam int INDEX_W   = 32;
    localparam int SCRIPT_W  = 8;
    localparam int COUNT_W   = 9;
    localparam int STATUS_W  = 3;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_SCRIPT   = 3'd1,
        ST_OVERFLOW = 3'd2,
        ST_FULL     = 3'd3,
        ST_NOMATCH  = 3'd4
    } status_t;

    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    typedef struct packed {
        logic [ID_WORDS-1:0][WORD_W-1:0] id;
        logic [INDEX_W-1:0]              index;
    } key_t;

    typedef struct packed {
        key_t              key;
        logic [WORD_W-1:0] value;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        status_t            status;
        logic [COUNT_W-1:0] count;
        logic [WORD_W-1:0]  balance;
    } result_t;

endpackage

// ----- sv/uot_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uot_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module uot_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/uot_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uot_engine
// Request sequencer: appends on add, scans the entry RAM on remove and
// back-fills the freed slot from the last entry.
// ----------------------------------------------------------------------------
module uot_engine
    import uot_pkg::*;
#(
    parameter int CAPACITY         = 256,
    parameter int MAX_SCRIPT_BYTES = 64,
    localparam int ADDR_W = $clog2(CAPACITY),
    localparam int CNT_W  = $clog2(CAPACITY + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                command,
    input  logic [WORD_W-1:0]   txid_word0,
    input  logic [WORD_W-1:0]   txid_word1,
    input  logic [WORD_W-1:0]   txid_word2,
    input  logic [WORD_W-1:0]   txid_word3,
    input  logic [INDEX_W-1:0]  output_index,
    input  logic [WORD_W-1:0]   amount,
    input  logic [SCRIPT_W-1:0] script_length,
    output logic                ram_we,
    output logic [ADDR_W-1:0]   ram_waddr,
    output entry_t              ram_wdata,
    output logic [ADDR_W-1:0]   ram_raddr,
    input  entry_t              ram_rdata,
    output logic                res_valid,
    output result_t             res,
    input  logic                res_take
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_LAST = 5'b00100,
        S_MOVE = 5'b01000,
        S_EMIT = 5'b10000
    } state_t;

    state_t              state_reg;
    logic [CNT_W-1:0]    held_reg;
    logic [WORD_W-1:0]   total_reg;
    key_t                key_reg;
    logic [CNT_W-1:0]    issue_reg;
    logic                rd_valid_reg;
    logic [ADDR_W-1:0]   rd_slot_reg;
    logic [ADDR_W-1:0]   hit_slot_reg;
    status_t             status_reg;

    logic                accept;
    key_t                in_key;
    logic [WORD_W:0]     sum;
    status_t             add_status;
    logic [CNT_W-1:0]    last;
    logic [ADDR_W-1:0]   last_addr;
    logic                match;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && (state_reg == S_IDLE);

    assign in_key.id[0] = txid_word0;
    assign in_key.id[1] = txid_word1;
    assign in_key.id[2] = txid_word2;
    assign in_key.id[3] = txid_word3;
    assign in_key.index = output_index;

    // carry out of the 65-bit sum marks a total past 2^64-1
    assign sum       = {1'b0, total_reg} + {1'b0, amount};
    assign last      = held_reg - CNT_W'(1);
    assign last_addr = last[ADDR_W-1:0];
    assign match     = rd_valid_reg && (ram_rdata.key == key_reg);

    always_comb
    begin
        if (script_length > SCRIPT_W'(MAX_SCRIPT_BYTES))
            add_status = ST_SCRIPT;
        else if (sum[WORD_W])
            add_status = ST_OVERFLOW;
        else if (held_reg == CNT_W'(CAPACITY))
            add_status = ST_FULL;
        else
            add_status = ST_OK;
    end

    always_comb
    begin
        ram_raddr = (state_reg == S_LAST) ? last_addr : issue_reg[ADDR_W-1:0];
        ram_we    = 1'b0;
        ram_waddr = held_reg[ADDR_W-1:0];
        ram_wdata.key   = in_key;
        ram_wdata.value = amount;
        if (accept && (command == CMD_ADD) && (add_status == ST_OK))
        begin
            ram_we = 1'b1;
        end
        else if ((state_reg == S_MOVE) && (hit_slot_reg != last_addr))
        begin
            // back-fill the freed slot with the last entry
            ram_we    = 1'b1;
            ram_waddr = hit_slot_reg;
            ram_wdata = ram_rdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            held_reg     <= '0;
            total_reg    <= '0;
            issue_reg    <= '0;
            rd_valid_reg <= 1'b0;
            status_reg   <= ST_OK;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (command == CMD_ADD)
                        begin
                            status_reg <= add_status;
                            if (add_status == ST_OK)
                            begin
                                held_reg  <= held_reg + CNT_W'(1);
                                total_reg <= sum[WORD_W-1:0];
                            end
                            state_reg <= S_EMIT;
                        end
                        else if (held_reg == '0)
                        begin
                            status_reg <= ST_NOMATCH;
                            state_reg  <= S_EMIT;
                        end
                        else
                        begin
                            issue_reg    <= '0;
                            rd_valid_reg <= 1'b0;
                            state_reg    <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    rd_valid_reg <= (issue_reg < held_reg);
                    if (issue_reg < held_reg)
                    begin
                        issue_reg <= issue_reg + CNT_W'(1);
                    end
                    if (match)
                    begin
                        total_reg <= total_reg - ram_rdata.value;
                        state_reg <= S_LAST;
                    end
                    else if (rd_valid_reg && (rd_slot_reg == last_addr))
                    begin
                        status_reg <= ST_NOMATCH;
                        state_reg  <= S_EMIT;
                    end
                end
                S_LAST:
                begin
                    state_reg <= S_MOVE;
                end
                S_MOVE:
                begin
                    held_reg   <= last;
                    status_reg <= ST_OK;
                    state_reg  <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (res_take)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // slot pipeline alongside the read, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg <= in_key;
        end
        if (state_reg == S_SCAN)
        begin
            rd_slot_reg <= issue_reg[ADDR_W-1:0];
            if (match)
            begin
                hit_slot_reg <= rd_slot_reg;
            end
        end
    end

    assign res_valid   = (state_reg == S_EMIT);
    assign res.status  = status_reg;
    assign res.count   = COUNT_W'(held_reg);
    assign res.balance = total_reg;

endmodule

// ----- sv/uot_out.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uot_out
// Result register between the sequencer and the downstream receiver.
// ----------------------------------------------------------------------------
module uot_out
    import uot_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                res_valid,
    input  result_t             res,
    output logic                res_take,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STATUS_W-1:0] status,
    output logic [COUNT_W-1:0]  entry_count,
    output logic [WORD_W-1:0]   balance
);

    logic    out_valid_reg;
    result_t out_res_reg;

    assign res_take = res_valid && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_res_reg.status;
    assign entry_count = out_res_reg.count;
    assign balance     = out_res_reg.balance;

endmodule

// ----- sv/unspent_output_table_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unspent_output_table_top
// Table of unspent outputs with running balance, held in one entry RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on in_valid/in_stall, one at a time; in_stall is high
//   from the cycle after acceptance until the result has been handed to the
//   output register. Each request gives exactly one result on
//   out_valid/out_stall (status, entry_count, balance).
//   Add: checks script length, total overflow and table space in that
//   order, and appends into the RAM.
//   Remove: the entry RAM is scanned one slot per cycle through its single
//   read port; a hit back-fills the slot from the last entry.
//   A new request is taken while a result still waits in the output
//   register; a stalled receiver holds the result and blocks the next
//   completion only.
//   Reset empties the table (count and balance zero) at once; the RAM
//   contents are not cleared, as only slots below the count are read.
// ----------------------------------------------------------------------------
module unspent_output_table_top
    import uot_pkg::*;
#(
    parameter int CAPACITY         = 256,
    parameter int MAX_SCRIPT_BYTES = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 command,
    input  logic [WORD_W-1:0]    txid_word0,
    input  logic [WORD_W-1:0]    txid_word1,
    input  logic [WORD_W-1:0]    txid_word2,
    input  logic [WORD_W-1:0]    txid_word3,
    input  logic [INDEX_W-1:0]   output_index,
    input  logic [WORD_W-1:0]    amount,
    input  logic [SCRIPT_W-1:0]  script_length,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [STATUS_W-1:0]  status,
    output logic [COUNT_W-1:0]   entry_count,
    output logic [WORD_W-1:0]    balance
);

    localparam int ADDR_W = $clog2(CAPACITY);

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    entry_t            ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    entry_t            ram_rdata;
    logic              res_valid;
    result_t           res;
    logic              res_take;

    uot_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    uot_engine #(
        .CAPACITY         (CAPACITY),
        .MAX_SCRIPT_BYTES (MAX_SCRIPT_BYTES)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .txid_word0    (txid_word0),
        .txid_word1    (txid_word1),
        .txid_word2    (txid_word2),
        .txid_word3    (txid_word3),
        .output_index  (output_index),
        .amount        (amount),
        .script_length (script_length),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .ram_raddr     (ram_raddr),
        .ram_rdata     (ram_rdata),
        .res_valid     (res_valid),
        .res           (res),
        .res_take      (res_take)
    );

    uot_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .res_valid   (res_valid),
        .res         (res),
        .res_take    (res_take),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .entry_count (entry_count),
        .balance     (balance)
    );

endmodule

// ----- sv/uot_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uot_checker
// Port-level checks on the unspent output table, bound to the top level.
// ----------------------------------------------------------------------------
module uot_checker
    import uot_pkg::*;
#(
    parameter int CAPACITY = 256
) (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input logic [STATUS_W-1:0] status,
    input logic [COUNT_W-1:0]  entry_count
);

    localparam logic [COUNT_W-1:0] CAP_COUNT = COUNT_W'(CAPACITY);
    localparam logic               CAP_WRAPS = (CAPACITY > 511);

    // a request never completes in its own cycle, so the port goes busy
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after request");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status)
            && $stable(entry_count))
        else $error("stalled result changed");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_FULL) |-> entry_count == CAP_COUNT)
        else $error("table full reported below capacity");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> CAP_WRAPS || (entry_count <= CAP_COUNT))
        else $error("entry count above capacity");

endmodule

bind unspent_output_table_top uot_checker #(
    .CAPACITY (CAPACITY)
) u_uot_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .entry_count (entry_count)
);
